// ===== hdl/adwc_pkg.sv =====
// Package for the adaptive draft width controller: field widths, register
// indexes and reset values of the configuration registers.
// No dependencies.
`default_nettype none

package adwc_pkg;

  // Field widths
  localparam int unsigned WIDTH_W   = 7;
  localparam int unsigned TH_W      = 17;
  localparam int unsigned BUDGET_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned S_DATA_W  = 32;
  localparam int unsigned M_DATA_W  = 32;

  // Largest width the controller will ever grant
  localparam int unsigned MAX_WIDTH_C = 64;
  localparam logic [WIDTH_W-1:0] WIDTH_CAP = WIDTH_W'(MAX_WIDTH_C);

  // Default number of fraction bits of the acceptance average
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GROW_TH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHRINK_TH    = 3'd4;

  // Item kinds
  localparam logic KIND_PLAN    = 1'b0;
  localparam logic KIND_OBSERVE = 1'b1;

  // Reset values
  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST    = 7'd1;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST    = 7'd8;
  localparam logic [WIDTH_W-1:0] WARMUP_WIDTH_RST = 7'd4;
  localparam logic [TH_W-1:0]    GROW_TH_RST      = 17'd52429;
  localparam logic [TH_W-1:0]    SHRINK_TH_RST    = 17'd26214;

endpackage

`default_nettype wire

// ===== hdl/adaptive_draft_width_controller.sv =====
// Adaptive draft width controller: plan/observe item stream, bit-serial
// acceptance ratio divider, bit-serial divide-by-five for the moving average.
// Depends on adwc_pkg.
//
//  channel | dir | handshake                   | payload
//  --------+-----+-----------------------------+-------------------------------
//  s_axis  | in  | s_axis_tvalid/s_axis_tready | tdata, tuser (item)
//  m_axis  | out | m_axis_tvalid/m_axis_tready | tdata (result)
//  cfg     | in  | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// Plan items and observe items with nothing proposed go straight to the finish
// state. An observe item runs the ratio divider; the first one after reset or a
// config write then sets the average to the ratio, later ones first add the
// divide-by-five pass, average = (4*average + ratio)/5, before the width update.
// The output register lets the next item in while a result waits; a stalled
// output holds the core in its finish state. Reset is asynchronous, active low.
`default_nettype none

module adaptive_draft_width_controller #(
  parameter int unsigned FRAC_BITS = adwc_pkg::FRAC_BITS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // Item stream in
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] remaining_budget, [22:16] proposed, [29:23] accepted, [31:30] zero
  input  wire  [adwc_pkg::S_DATA_W-1:0]       s_axis_tdata,
  // [0] kind
  input  wire                                 s_axis_tuser,
  // Result stream out
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // [6:0] draft_width, [13:7] current_width, [30:14] acceptance_ema, [31] zero
  output logic [adwc_pkg::M_DATA_W-1:0]       m_axis_tdata,
  // Configuration writes
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [adwc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [adwc_pkg::TH_W-1:0]           cfg_data_i
);

  import adwc_pkg::*;

  localparam int unsigned EW    = FRAC_BITS + 1;     // average / ratio width
  localparam int unsigned SUM_W = FRAC_BITS + 3;     // 4*ema + ratio
  localparam int unsigned CW    = (EW > TH_W) ? EW : TH_W;
  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 4);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_RATIO = 7'b0000010,
    ST_SUM   = 7'b0000100,
    ST_DIV5  = 7'b0001000,
    ST_EMA   = 7'b0010000,
    ST_WIDTH = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [WIDTH_W-1:0]  prop_q, prop_d;
  logic [WIDTH_W-1:0]  rem_q, rem_d;
  logic [EW-1:0]       quo_q, quo_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [2:0]          rem5_q, rem5_d;

  logic [WIDTH_W-1:0]  min_q, min_d, max_q, max_d, warm_q, warm_d;
  logic [TH_W-1:0]     grow_q, grow_d, shrink_q, shrink_d;
  logic [WIDTH_W-1:0]  width_q, width_d;
  logic [EW-1:0]       ema_q, ema_d;
  logic                seen_q, seen_d;
  logic [WIDTH_W-1:0]  draft_q, draft_d;

  logic                out_valid_q, out_valid_d;
  logic [M_DATA_W-1:0] out_data_q, out_data_d;

  // Item field views
  logic                in_kind;
  logic [BUDGET_W-1:0] in_budget;
  logic [WIDTH_W-1:0]  in_prop, in_acc, acc_sat;

  // Serial step helpers
  logic [WIDTH_W:0]    div_t;
  logic                div_ge;
  logic [3:0]          d5_t;
  logic                d5_ge;
  logic                out_free;
  logic [CW-1:0]       ema_ext, grow_ext, shrink_ext;

  // Config renormalization
  logic [WIDTH_W-1:0]  new_min, new_max, new_warm, n_min, n_max, n_width;

  assign in_kind   = s_axis_tuser;
  assign in_budget = s_axis_tdata[BUDGET_W-1:0];
  assign in_prop   = s_axis_tdata[22:16];
  assign in_acc    = s_axis_tdata[29:23];
  assign acc_sat   = (in_acc > in_prop) ? in_prop : in_acc;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Ratio divider step: first step compares without shifting
  assign div_t  = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign div_ge = (div_t >= {1'b0, prop_q});

  // Divide-by-five step: one dividend bit per cycle
  assign d5_t  = {rem5_q, sum_q[SUM_W-1]};
  assign d5_ge = (d5_t >= 4'd5);

  assign ema_ext    = CW'(ema_q);
  assign grow_ext   = CW'(grow_q);
  assign shrink_ext = CW'(shrink_q);

  // Register values after a config write, then renormalized
  always_comb begin
    new_min  = min_q;
    new_max  = max_q;
    new_warm = warm_q;
    case (cfg_index_i)
      CFG_MIN_WIDTH:    new_min  = cfg_data_i[WIDTH_W-1:0];
      CFG_MAX_WIDTH:    new_max  = cfg_data_i[WIDTH_W-1:0];
      CFG_WARMUP_WIDTH: new_warm = cfg_data_i[WIDTH_W-1:0];
      default:          ;
    endcase
    if (new_min == '0) begin
      n_min = WIDTH_W'(1);
    end else if (new_min > WIDTH_CAP) begin
      n_min = WIDTH_CAP;
    end else begin
      n_min = new_min;
    end
    n_max = (new_max > WIDTH_CAP) ? WIDTH_CAP : new_max;
    if (n_max < n_min) begin
      n_max = n_min;
    end
    if (new_warm < n_min) begin
      n_width = n_min;
    end else if (new_warm > n_max) begin
      n_width = n_max;
    end else begin
      n_width = new_warm;
    end
  end

  // Sequencer and datapath
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    prop_d      = prop_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    sum_d       = sum_q;
    rem5_d      = rem5_q;
    min_d       = min_q;
    max_d       = max_q;
    warm_d      = warm_q;
    grow_d      = grow_q;
    shrink_d    = shrink_q;
    width_d     = width_q;
    ema_d       = ema_q;
    seen_d      = seen_q;
    draft_d     = draft_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          draft_d = '0;
          state_d = ST_DONE;
          if (in_kind == KIND_PLAN) begin
            if (in_budget != '0) begin
              draft_d = ({{(BUDGET_W-WIDTH_W){1'b0}}, width_q} < in_budget) ?
                        width_q : in_budget[WIDTH_W-1:0];
            end
          end else if (in_prop != '0) begin
            prop_d  = in_prop;
            rem_d   = acc_sat;
            cnt_d   = '0;
            state_d = ST_RATIO;
          end
        end
      end
      ST_RATIO: begin
        rem_d = div_ge ? WIDTH_W'(div_t - {1'b0, prop_q}) : div_t[WIDTH_W-1:0];
        quo_d = {quo_q[EW-2:0], div_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(EW - 1)) begin
          state_d = seen_q ? ST_SUM : ST_EMA;
        end
      end
      ST_SUM: begin
        sum_d   = {ema_q, 2'b00} + SUM_W'(quo_q);
        rem5_d  = '0;
        cnt_d   = '0;
        state_d = ST_DIV5;
      end
      ST_DIV5: begin
        rem5_d = d5_ge ? 3'(d5_t - 4'd5) : d5_t[2:0];
        sum_d  = {sum_q[SUM_W-2:0], 1'b0};
        quo_d  = {quo_q[EW-2:0], d5_ge};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SUM_W - 1)) begin
          state_d = ST_EMA;
        end
      end
      ST_EMA: begin
        ema_d   = quo_q;
        seen_d  = 1'b1;
        state_d = ST_WIDTH;
      end
      ST_WIDTH: begin
        if (ema_ext >= grow_ext && width_q < max_q) begin
          width_d = width_q + 1'b1;
        end else if (ema_ext <= shrink_ext && width_q > min_q) begin
          width_d = width_q - 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {1'b0, TH_W'(ema_q), width_q, draft_q};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Config write: store, renormalize, restart width and average
    if (cfg_valid_i && cfg_index_i <= CFG_SHRINK_TH) begin
      min_d   = n_min;
      max_d   = n_max;
      warm_d  = new_warm;
      width_d = n_width;
      ema_d   = '0;
      seen_d  = 1'b0;
      if (cfg_index_i == CFG_GROW_TH) begin
        grow_d = cfg_data_i;
      end
      if (cfg_index_i == CFG_SHRINK_TH) begin
        shrink_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      prop_q      <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      sum_q       <= '0;
      rem5_q      <= '0;
      min_q       <= MIN_WIDTH_RST;
      max_q       <= MAX_WIDTH_RST;
      warm_q      <= WARMUP_WIDTH_RST;
      grow_q      <= GROW_TH_RST;
      shrink_q    <= SHRINK_TH_RST;
      width_q     <= WARMUP_WIDTH_RST;
      ema_q       <= '0;
      seen_q      <= 1'b0;
      draft_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      prop_q      <= prop_d;
      rem_q       <= rem_d;
      quo_q       <= quo_d;
      sum_q       <= sum_d;
      rem5_q      <= rem5_d;
      min_q       <= min_d;
      max_q       <= max_d;
      warm_q      <= warm_d;
      grow_q      <= grow_d;
      shrink_q    <= shrink_d;
      width_q     <= width_d;
      ema_q       <= ema_d;
      seen_q      <= seen_d;
      draft_q     <= draft_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  // Width stays inside the normalized bounds
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (min_q != '0) && (min_q <= width_q) && (width_q <= max_q) && (max_q <= WIDTH_CAP))
    else $error("width outside normalized bounds");

  // Average never exceeds one
  a_ema_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ema_q <= EW'(1) << FRAC_BITS)
    else $error("acceptance average above one");

  // Divider remainder stays at or below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RATIO) |-> (rem_q <= prop_q))
    else $error("ratio remainder out of range");

  // A finished item leaves through the output register
  a_done_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished item not pushed to output");

endmodule

`default_nettype wire
